// File: rtl/cau_pkg.sv
package cau_pkg;

  // Operation codes carried in the cmd field.
  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  // Datapath widths.
  localparam int OPW   = 16;  // operand part width
  localparam int RESW  = 32;  // result part width
  localparam int MW    = 49;  // intermediate width before saturation
  localparam int DVD_W = 48;  // divider dividend and quotient width
  localparam int DEN_W = 32;  // divider denominator width
  localparam int RAD_W = 64;  // square root radicand width
  localparam int ROOT_W = 32; // square root result width

  // Information that rides alongside the divider lanes.
  typedef struct packed {
    logic            vld;
    logic            is_div;
    logic            dz;
    logic            neg_re;
    logic            neg_im;
    logic [RESW-1:0] re;
    logic [RESW-1:0] im;
  } div_side_t;

  // Information that rides alongside the square root pipeline.
  typedef struct packed {
    logic            vld;
    logic            dz;
    logic [RESW-1:0] re;
    logic [RESW-1:0] im;
  } sq_side_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic [RESW-1:0] sat32(input logic signed [MW-1:0] v);
    logic [RESW-1:0] r;
    if (v[MW-1:RESW-1] == {(MW-RESW+1){1'b0}} ||
        v[MW-1:RESW-1] == {(MW-RESW+1){1'b1}}) begin
      r = v[RESW-1:0];
    end else if (v[MW-1]) begin
      r = {1'b1, {(RESW-1){1'b0}}};
    end else begin
      r = {1'b0, {(RESW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// File: rtl/complex_arithmetic_unit.sv
// Complex arithmetic unit.
// The input channel (in_valid / in_stall) takes two complex operands a and b
// in signed fixed point with FRAC_BITS fraction bits and a command: add,
// subtract, multiply or divide a by b. The output channel (out_valid /
// out_stall) returns one item per input item: the real and imaginary parts in
// saturated signed Q16.16, the floor magnitude in unsigned Q16.16, and a flag
// for a divide by zero, in which case the three values are zero.
// From acceptance to out_valid, every item passes three front stages, a
// 48-stage divider, three stages for the final sign and saturation, squares
// and their sum, a 32-stage square root and the output register. All commands
// take the same path, so items leave in order.
// A new item can be accepted in every cycle in which the output is not held.
// When the receiver stalls while out_valid is high, the whole pipeline holds
// and in_stall rises in the same cycle; nothing is lost or repeated.
// Reset clears every valid bit, so the block comes out of reset empty and
// ready to accept an item at once.
module complex_arithmetic_unit
  import cau_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_cmd,
  input  logic signed [OPW-1:0]  in_a_re,
  input  logic signed [OPW-1:0]  in_a_im,
  input  logic signed [OPW-1:0]  in_b_re,
  input  logic signed [OPW-1:0]  in_b_im,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [RESW-1:0] out_res_re,
  output logic signed [RESW-1:0] out_res_im,
  output logic [RESW-1:0]        out_magnitude,
  output logic                   out_div_by_zero
);

  localparam int ADD_SH  = 16 - FRAC_BITS;
  localparam int MUL_SH  = 16 - 2 * FRAC_BITS;
  localparam int MUL_LSH = (MUL_SH > 0) ? MUL_SH : 0;
  localparam int MUL_RSH = (MUL_SH < 0) ? -MUL_SH : 0;
  localparam logic signed [MW-1:0] MUL_BIAS = MW'((64'd1 << MUL_RSH) - 64'd1);

  logic en;

  // The whole pipeline advances unless a finished item is held at the output.
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // Input register.
  logic                  v0_r;
  logic [1:0]            cmd0_r;
  logic signed [OPW-1:0] ar0_r, ai0_r, br0_r, bi0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd0_r <= in_cmd;
      ar0_r  <= in_a_re;
      ai0_r  <= in_a_im;
      br0_r  <= in_b_re;
      bi0_r  <= in_b_im;
    end
  end

  // Stage 1: partial products, squares of b and the sum or difference.
  logic                   v1_r;
  logic [1:0]             cmd1_r;
  logic signed [RESW-1:0] p_rr1_r, p_ii1_r, p_ri1_r, p_ir1_r, d_rr1_r, d_ii1_r;
  logic signed [OPW:0]    s_re1_r, s_im1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1_r  <= cmd0_r;
      p_rr1_r <= ar0_r * br0_r;
      p_ii1_r <= ai0_r * bi0_r;
      p_ri1_r <= ar0_r * bi0_r;
      p_ir1_r <= ai0_r * br0_r;
      d_rr1_r <= br0_r * br0_r;
      d_ii1_r <= bi0_r * bi0_r;
      if (cmd0_r == CMD_SUB) begin
        s_re1_r <= (OPW+1)'(ar0_r) - (OPW+1)'(br0_r);
        s_im1_r <= (OPW+1)'(ai0_r) - (OPW+1)'(bi0_r);
      end else begin
        s_re1_r <= (OPW+1)'(ar0_r) + (OPW+1)'(br0_r);
        s_im1_r <= (OPW+1)'(ai0_r) + (OPW+1)'(bi0_r);
      end
    end
  end

  // Stage 2: rescale and saturate add, subtract and multiply; set up division.
  logic signed [MW-1:0]   add_re, add_im, mul_re, mul_im, mul_re_s, mul_im_s;
  logic signed [RESW:0]   num_re, num_im;
  logic [RESW:0]          mag_re, mag_im;
  logic [DEN_W-1:0]       den;
  div_side_t              side2;
  logic [DVD_W-1:0]       dvd_re2_r, dvd_im2_r;
  logic [DEN_W-1:0]       den2_r;
  div_side_t              side2_r;

  always_comb begin
    add_re   = MW'(s_re1_r) <<< ADD_SH;
    add_im   = MW'(s_im1_r) <<< ADD_SH;
    mul_re   = MW'(p_rr1_r) - MW'(p_ii1_r);
    mul_im   = MW'(p_ri1_r) + MW'(p_ir1_r);
    // Arithmetic right shifts round toward minus infinity, so negative values get a bias first to truncate toward zero.
    mul_re_s = ($signed(mul_re + (mul_re[MW-1] ? MUL_BIAS : '0)) >>> MUL_RSH) <<< MUL_LSH;
    mul_im_s = ($signed(mul_im + (mul_im[MW-1] ? MUL_BIAS : '0)) >>> MUL_RSH) <<< MUL_LSH;
    num_re   = (RESW+1)'(p_rr1_r) + (RESW+1)'(p_ii1_r);
    num_im   = (RESW+1)'(p_ir1_r) - (RESW+1)'(p_ri1_r);
    mag_re   = num_re[RESW] ? (RESW+1)'(-num_re) : num_re;
    mag_im   = num_im[RESW] ? (RESW+1)'(-num_im) : num_im;
    den      = DEN_W'(d_rr1_r) + DEN_W'(d_ii1_r);

    side2        = '0;
    side2.vld    = v1_r;
    side2.neg_re = num_re[RESW];
    side2.neg_im = num_im[RESW];
    case (cmd1_r)
      CMD_ADD, CMD_SUB: begin
        side2.re = sat32(add_re);
        side2.im = sat32(add_im);
      end
      CMD_MUL: begin
        side2.re = sat32(mul_re_s);
        side2.im = sat32(mul_im_s);
      end
      CMD_DIV: begin
        side2.is_div = 1'b1;
        side2.dz     = (den == '0);
      end
      default: begin
        side2.is_div = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side2_r.vld <= 1'b0;
    end else if (en) begin
      side2_r <= side2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dvd_re2_r <= {mag_re[RESW-1:0], 16'd0};
      dvd_im2_r <= {mag_im[RESW-1:0], 16'd0};
      den2_r    <= (den == '0) ? DEN_W'(1) : den;
    end
  end

  // Quotient magnitudes, one divider per part.
  logic [DVD_W-1:0] q_re, q_im;

  cau_div u_div_re (
    .clk (clk),
    .en  (en),
    .dvd (dvd_re2_r),
    .den (den2_r),
    .quo (q_re)
  );

  cau_div u_div_im (
    .clk (clk),
    .en  (en),
    .dvd (dvd_im2_r),
    .den (den2_r),
    .quo (q_im)
  );

  // Side information follows the divider stages.
  div_side_t dside_r [DVD_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DVD_W; i++) begin
        dside_r[i].vld <= 1'b0;
      end
    end else if (en) begin
      dside_r[0] <= side2_r;
      for (int i = 1; i < DVD_W; i++) begin
        dside_r[i] <= dside_r[i-1];
      end
    end
  end

  // Stage 3: sign and saturate the quotients, pick the final parts.
  div_side_t       dout;
  logic [RESW-1:0] re_nxt, im_nxt;
  logic            v3_r, dz3_r;
  logic [RESW-1:0] re3_r, im3_r;

  function automatic logic [RESW-1:0] sign_sat(input logic [DVD_W-1:0] q,
                                               input logic neg);
    logic [RESW-1:0] r;
    if (!neg) begin
      r = (q > DVD_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[RESW-1:0];
    end else begin
      r = (q > DVD_W'(32'h8000_0000)) ? 32'h8000_0000 : RESW'(-q[RESW-1:0]);
    end
    return r;
  endfunction

  always_comb begin
    dout   = dside_r[DVD_W-1];
    re_nxt = dout.re;
    im_nxt = dout.im;
    if (dout.is_div) begin
      if (dout.dz) begin
        re_nxt = '0;
        im_nxt = '0;
      end else begin
        re_nxt = sign_sat(q_re, dout.neg_re);
        im_nxt = sign_sat(q_im, dout.neg_im);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= dout.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dz3_r <= dout.is_div && dout.dz;
      re3_r <= re_nxt;
      im3_r <= im_nxt;
    end
  end

  // Stage 4: squares of both parts.
  logic                   v4_r, dz4_r;
  logic [RESW-1:0]        re4_r, im4_r;
  logic signed [RAD_W-1:0] sq_re4_r, sq_im4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dz4_r    <= dz3_r;
      re4_r    <= re3_r;
      im4_r    <= im3_r;
      sq_re4_r <= $signed(re3_r) * $signed(re3_r);
      sq_im4_r <= $signed(im3_r) * $signed(im3_r);
    end
  end

  // Stage 5: sum of squares.
  sq_side_t         side5_r;
  logic [RAD_W-1:0] rad5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side5_r.vld <= 1'b0;
    end else if (en) begin
      side5_r <= {v4_r, dz4_r, re4_r, im4_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad5_r <= RAD_W'(sq_re4_r) + RAD_W'(sq_im4_r);
    end
  end

  // Magnitude.
  logic [ROOT_W-1:0] root;

  cau_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (rad5_r),
    .root (root)
  );

  sq_side_t sside_r [ROOT_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ROOT_W; i++) begin
        sside_r[i].vld <= 1'b0;
      end
    end else if (en) begin
      sside_r[0] <= side5_r;
      for (int i = 1; i < ROOT_W; i++) begin
        sside_r[i] <= sside_r[i-1];
      end
    end
  end

  // Output register.
  logic            out_valid_r, out_dz_r;
  logic [RESW-1:0] out_re_r, out_im_r, out_mag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sside_r[ROOT_W-1].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_dz_r  <= sside_r[ROOT_W-1].dz;
      out_re_r  <= sside_r[ROOT_W-1].re;
      out_im_r  <= sside_r[ROOT_W-1].im;
      out_mag_r <= root;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_res_re      = $signed(out_re_r);
  assign out_res_im      = $signed(out_im_r);
  assign out_magnitude   = out_mag_r;
  assign out_div_by_zero = out_dz_r;

endmodule

// File: rtl/cau_div.sv
// Pipelined restoring divider: one quotient bit per stage, one item per cycle while en is high.
module cau_div
  import cau_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [DVD_W-1:0] dvd,
  input  logic [DEN_W-1:0] den,
  output logic [DVD_W-1:0] quo
);

  logic [DEN_W-1:0] rem_r [DVD_W];
  logic [DVD_W-1:0] dvd_r [DVD_W];
  logic [DVD_W-1:0] quo_r [DVD_W];
  logic [DEN_W-1:0] den_r [DVD_W];

  for (genvar s = 0; s < DVD_W; s++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [DVD_W-1:0] dvd_in;
    logic [DVD_W-1:0] quo_in;
    logic [DEN_W-1:0] den_in;
    logic [DEN_W:0]   trial;
    logic             ge;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign dvd_in = dvd;
      assign quo_in = '0;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign dvd_in = dvd_r[s-1];
      assign quo_in = quo_r[s-1];
      assign den_in = den_r[s-1];
    end

    // Bring down the next dividend bit and try a subtraction.
    assign trial = {rem_in, dvd_in[DVD_W-1]};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
        dvd_r[s] <= {dvd_in[DVD_W-2:0], 1'b0};
        quo_r[s] <= {quo_in[DVD_W-2:0], ge};
        den_r[s] <= den_in;
      end
    end
  end

  assign quo = quo_r[DVD_W-1];

endmodule

// File: rtl/cau_sqrt.sv
// Pipelined integer square root: one root bit per stage, one item per cycle while en is high.
module cau_sqrt
  import cau_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [RAD_W-1:0]  rad,
  output logic [ROOT_W-1:0] root
);

  localparam int REM_W = ROOT_W + 2;

  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [RAD_W-1:0]  rad_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    logic [REM_W-1:0]  rem_in;
    logic [RAD_W-1:0]  rad_in;
    logic [ROOT_W-1:0] root_in;
    logic [REM_W+1:0]  cur;
    logic [REM_W+1:0]  trial;
    logic              ge;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign rad_in  = rad;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[s-1];
      assign rad_in  = rad_r[s-1];
      assign root_in = root_r[s-1];
    end

    // Append the next two radicand bits and test the trial root.
    assign cur   = {rem_in, rad_in[RAD_W-1:RAD_W-2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= ge ? REM_W'(cur - trial) : cur[REM_W-1:0];
        rad_r[s]  <= {rad_in[RAD_W-3:0], 2'b00};
        root_r[s] <= {root_in[ROOT_W-2:0], ge};
      end
    end
  end

  assign root = root_r[ROOT_W-1];

endmodule

// File: verif/cau_checker.sv
`timescale 1ns / 100ps

module cau_checker
  import cau_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [1:0]             in_cmd,
  input  logic signed [OPW-1:0]  in_a_re,
  input  logic signed [OPW-1:0]  in_a_im,
  input  logic signed [OPW-1:0]  in_b_re,
  input  logic signed [OPW-1:0]  in_b_im,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic signed [RESW-1:0] out_res_re,
  input  logic signed [RESW-1:0] out_res_im,
  input  logic [RESW-1:0]        out_magnitude,
  input  logic                   out_div_by_zero,
  output int                     fail_count,
  output int                     pending
);

  typedef struct {
    logic signed [RESW-1:0] re;
    logic signed [RESW-1:0] im;
    logic [RESW-1:0]        mag;
    logic                   dz;
  } cplx_result_t;

  cplx_result_t expected_q[$];

  // Rescale a value with frac fraction bits to Q16.16, truncating toward zero.
  function automatic longint rescale_q16(longint v, int frac);
    longint d;
    if (frac <= 16) begin
      return v * (64'sd1 <<< (16 - frac));
    end
    d = 64'sd1 <<< (frac - 16);
    return v / d;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Bitwise floor square root of a 64-bit unsigned value.
  function automatic logic [63:0] floor_sqrt(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic cplx_result_t compute_complex(logic [1:0] cmd, longint ar, longint ai,
                                                   longint br, longint bi);
    cplx_result_t res;
    longint re;
    longint im;
    longint den;
    logic [63:0] sum;
    logic [63:0] root;
    re = 0;
    im = 0;
    res.dz = 1'b0;
    case (cmd)
      CMD_ADD: begin
        re = rescale_q16(ar + br, FRAC_BITS);
        im = rescale_q16(ai + bi, FRAC_BITS);
      end
      CMD_SUB: begin
        re = rescale_q16(ar - br, FRAC_BITS);
        im = rescale_q16(ai - bi, FRAC_BITS);
      end
      CMD_MUL: begin
        re = rescale_q16(ar * br - ai * bi, 2 * FRAC_BITS);
        im = rescale_q16(ar * bi + ai * br, 2 * FRAC_BITS);
      end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          res.dz = 1'b1;
        end else begin
          re = ((ar * br + ai * bi) * 65536) / den;
          im = ((ai * br - ar * bi) * 65536) / den;
        end
      end
    endcase
    re = clamp32(re);
    im = clamp32(im);
    sum = 64'(re * re) + 64'(im * im);
    root = floor_sqrt(sum);
    res.re = re[31:0];
    res.im = im[31:0];
    res.mag = (root > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : root[31:0];
    return res;
  endfunction

  // Predict on each accepted input item and check each accepted result.
  always @(posedge clk) begin
    cplx_result_t exp_r;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_q.push_back(compute_complex(in_cmd, in_a_re, in_a_im, in_b_re, in_b_im));
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result item");
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.re !== out_res_re || exp_r.im !== out_res_im ||
              exp_r.mag !== out_magnitude || exp_r.dz !== out_div_by_zero) begin
            fail_count <= fail_count + 1;
            if (exp_r.re !== out_res_re)
              $error("res_re expected %0d actual %0d", exp_r.re, out_res_re);
            if (exp_r.im !== out_res_im)
              $error("res_im expected %0d actual %0d", exp_r.im, out_res_im);
            if (exp_r.mag !== out_magnitude)
              $error("magnitude expected %0d actual %0d", exp_r.mag, out_magnitude);
            if (exp_r.dz !== out_div_by_zero)
              $error("div_by_zero expected %0d actual %0d", exp_r.dz, out_div_by_zero);
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import cau_pkg::*;

  localparam int LATENCY   = 87;
  localparam int IDLE_LIMIT = 20000;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [1:0]             in_cmd;
  logic signed [OPW-1:0]  in_a_re;
  logic signed [OPW-1:0]  in_a_im;
  logic signed [OPW-1:0]  in_b_re;
  logic signed [OPW-1:0]  in_b_im;
  logic                   out_valid;
  logic                   out_stall;
  logic signed [RESW-1:0] out_res_re;
  logic signed [RESW-1:0] out_res_im;
  logic [RESW-1:0]        out_magnitude;
  logic                   out_div_by_zero;
  int                     fail_count;
  int                     pending;
  int                     idle_cycles;
  bit                     hold_done;

  complex_arithmetic_unit u_top (.*);

  cau_checker u_checker (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Pick an operand part: mostly random, sometimes an extreme or zero.
  function automatic logic [15:0] pick_part();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(0, 1023)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one item and hold it until it is accepted.
  task automatic send_item(logic [1:0] cmd, logic [15:0] ar, logic [15:0] ai,
                           logic [15:0] br, logic [15:0] bi);
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_a_re  <= ar;
    in_a_im  <= ai;
    in_b_re  <= br;
    in_b_im  <= bi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Receiver stall pattern, with one long hold-off to fill the pipeline.
  initial begin
    int phase;
    out_stall = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_n);
    repeat (300) @(negedge clk);
    out_stall <= 1'b1;
    repeat (400) @(negedge clk);
    out_stall <= 1'b0;
    hold_done = 1'b1;
    forever begin
      phase = $urandom_range(0, 3);
      repeat ($urandom_range(1, 40)) begin
        @(negedge clk);
        out_stall <= (phase == 0) ? 1'b0 : ($urandom_range(0, 3) < phase);
      end
    end
  end

  // Watchdog on cycles with no accepted item.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Stimulus: directed corners, then random bursts with gaps.
  initial begin
    logic [15:0] corners[4];
    int burst;
    int n;
    corners = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_cmd   = CMD_ADD;
    in_a_re  = '0;
    in_a_im  = '0;
    in_b_re  = '0;
    in_b_im  = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Every command on extreme operands, plus divide by zero.
    for (int c = 0; c < 4; c++) begin
      send_item(2'(c), 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
      send_item(2'(c), 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_item(2'(c), 16'h0100, 16'hFF00, 16'h0001, 16'hFFFF);
      send_item(2'(c), 16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000);
    end
    send_item(CMD_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_item(CMD_DIV, 16'h7FFF, 16'h7FFF, 16'h0001, 16'h0000);
    send_item(CMD_DIV, 16'h8000, 16'h0000, 16'h0000, 16'hFFFF);
    send_item(CMD_MUL, 16'hFFFF, 16'h0001, 16'h0001, 16'hFFFF);
    send_item(CMD_SUB, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);

    // Random items: back-to-back bursts through the long hold-off too.
    n = 0;
    while (n < 2000) begin
      burst = $urandom_range(1, 30);
      repeat (burst) begin
        send_item(2'($urandom), pick_part(), pick_part(), pick_part(),
                  ($urandom_range(0, 15) == 0) ? corners[$urandom_range(0, 3)]
                                               : pick_part());
        n++;
      end
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
    in_valid <= 1'b0;

    while (pending != 0 || !hold_done) @(negedge clk);
    repeat (LATENCY + 20) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/cau_pkg.sv
rtl/cau_div.sv
rtl/cau_sqrt.sv
rtl/complex_arithmetic_unit.sv
verif/cau_checker.sv
verif/tb_top.sv
